// ----- rtl/mlr_pkg.sv -----
// ----------------------------------------------------------------------------
// Midpoint line rasterizer package
// Item types, opcodes, state codes and the decision variable width used
// by the rasterizer and its testbench.
// ----------------------------------------------------------------------------
`default_nettype none

package mlr_pkg;

    // Opcodes of a command item.
    localparam logic OP_DRAW = 1'b0;
    localparam logic OP_READ = 1'b1;

    // Coordinates are 8 bits, so the decision variable stays in -510..510.
    localparam int COORD_W = 8;
    localparam int DEC_W   = 11;

    typedef struct packed {
        logic               op;
        logic [COORD_W-1:0] x_start;
        logic [COORD_W-1:0] y_start;
        logic [COORD_W-1:0] x_end;
        logic [COORD_W-1:0] y_end;
    } cmd_item_t;

    typedef struct packed {
        logic pixel_on;
        logic was_read;
    } res_item_t;

    typedef enum logic [6:0] {
        ST_CLEAR  = 7'b0000001,
        ST_IDLE   = 7'b0000010,
        ST_SETUP1 = 7'b0000100,
        ST_SETUP2 = 7'b0001000,
        ST_DRAW   = 7'b0010000,
        ST_READ   = 7'b0100000,
        ST_FINISH = 7'b1000000
    } state_t;

endpackage

`default_nettype wire

// ----- rtl/mlr_ram.sv -----
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port, with the read data registered.
// ----------------------------------------------------------------------------
`default_nettype none

module mlr_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 65536
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// ----- rtl/midpoint_line_rasterizer_unit.sv -----
// ----------------------------------------------------------------------------
// Midpoint line rasterizer unit
// Draws lines into a one-bit-per-pixel bitmap and reads single pixels back.
// ----------------------------------------------------------------------------
// After reset the unit sweeps every address of the bitmap to zero, one pixel
// per cycle; no command item is taken until the sweep is done. A draw item
// then passes the setup states ST_SETUP1 and ST_SETUP2, sets one pixel per
// cycle on the line (the longer of |dx| and |dy|, plus one pixels), as the
// single decision variable adder and single bitmap write port allow, and
// hands over its result from ST_FINISH once the output register is free. A
// read item addresses the bitmap as it is taken and samples the registered
// read data in ST_READ. The unit works on one item at a time, but it takes
// the next item while a result still waits in the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module midpoint_line_rasterizer_unit
    import mlr_pkg::*;
#(
    parameter int SCREEN_WIDTH  = 256,
    parameter int SCREEN_HEIGHT = 256
) (
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      cmd_valid,
    output logic           cmd_stall,
    input  wire cmd_item_t cmd,
    output logic           res_valid,
    input  wire logic      res_stall,
    output res_item_t      res
);

    localparam int DEPTH = SCREEN_WIDTH * SCREEN_HEIGHT;
    localparam int AW    = $clog2(DEPTH);

    state_t              state_reg, state_next;
    logic [AW-1:0]       clr_addr_reg, clr_addr_next;
    logic                op_reg, op_next;
    logic [COORD_W-1:0]  xa_reg, xa_next, ya_reg, ya_next;
    logic [COORD_W-1:0]  xb_reg, xb_next, yb_reg, yb_next;
    logic [COORD_W-1:0]  adx_reg, adx_next, ady_reg, ady_next;
    logic                dx_pos_reg, dx_pos_next, dx_neg_reg, dx_neg_next;
    logic                dy_pos_reg, dy_pos_next, dy_neg_reg, dy_neg_next;
    logic                swap_reg, swap_next;
    logic                maj_neg_reg, maj_neg_next, min_neg_reg, min_neg_next;
    logic [DEC_W-1:0]    dec_reg, dec_next;
    logic [DEC_W-1:0]    inc_e_reg, inc_e_next, inc_ne_reg, inc_ne_next;
    logic [COORD_W-1:0]  cnt_reg, cnt_next;
    logic [COORD_W-1:0]  x_reg, x_next, y_reg, y_next;
    logic                inb_reg, inb_next;
    logic                pix_reg, pix_next;
    logic                res_valid_reg, res_valid_next;
    res_item_t           res_reg, res_next;

    logic                cmd_take;
    logic                out_free;
    logic                ram_we;
    logic [AW-1:0]       ram_waddr;
    logic [0:0]          ram_wdata;
    logic [AW-1:0]       ram_raddr;
    logic [0:0]          ram_rdata;
    logic [AW-1:0]       pix_addr;
    logic                pix_inb;
    logic                rd_inb;
    logic                swap_c;
    logic [COORD_W-1:0]  du, dv;
    logic [COORD_W-1:0]  maj_next_c, min_next_c;
    logic [DEC_W-1:0]    dec_sum;
    logic                dec_pos;

    assign cmd_stall = (state_reg != ST_IDLE);
    assign cmd_take  = cmd_valid && !cmd_stall;
    assign out_free  = !res_valid_reg || !res_stall;
    assign res_valid = res_valid_reg;
    assign res       = res_reg;

    // Screen address of the current line pixel and of a read position.
    assign pix_inb   = (32'(x_reg) < SCREEN_WIDTH) && (32'(y_reg) < SCREEN_HEIGHT);
    assign pix_addr  = AW'(32'(y_reg) * 32'(SCREEN_WIDTH) + 32'(x_reg));
    assign rd_inb    = (32'(cmd.x_start) < SCREEN_WIDTH) &&
                       (32'(cmd.y_start) < SCREEN_HEIGHT);
    assign ram_raddr = AW'(32'(cmd.y_start) * 32'(SCREEN_WIDTH) + 32'(cmd.x_start));

    // Setup arithmetic for the canonical octant.
    assign swap_c = !(adx_reg > ady_reg);
    assign du     = swap_c ? ady_reg : adx_reg;
    assign dv     = swap_c ? adx_reg : ady_reg;

    // The shared decision variable step.
    assign dec_pos = !dec_reg[DEC_W-1] && (dec_reg != '0);
    assign dec_sum = dec_reg + (dec_pos ? inc_ne_reg : inc_e_reg);

    always_comb
    begin
        ram_we    = 1'b0;
        ram_waddr = pix_addr;
        ram_wdata = 1'b1;
        case (state_reg)
            ST_CLEAR:
            begin
                ram_we    = 1'b1;
                ram_waddr = clr_addr_reg;
                ram_wdata = 1'b0;
            end
            ST_DRAW:
            begin
                ram_we = pix_inb;
            end
            default:
            begin
                ram_we = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        maj_next_c = 8'(swap_reg ? y_reg : x_reg);
        min_next_c = 8'(swap_reg ? x_reg : y_reg);
        maj_next_c = maj_neg_reg ? (maj_next_c - 8'd1) : (maj_next_c + 8'd1);
        if (dec_pos)
        begin
            min_next_c = min_neg_reg ? (min_next_c - 8'd1) : (min_next_c + 8'd1);
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        clr_addr_next  = clr_addr_reg;
        op_next        = op_reg;
        xa_next        = xa_reg;
        ya_next        = ya_reg;
        xb_next        = xb_reg;
        yb_next        = yb_reg;
        adx_next       = adx_reg;
        ady_next       = ady_reg;
        dx_pos_next    = dx_pos_reg;
        dx_neg_next    = dx_neg_reg;
        dy_pos_next    = dy_pos_reg;
        dy_neg_next    = dy_neg_reg;
        swap_next      = swap_reg;
        maj_neg_next   = maj_neg_reg;
        min_neg_next   = min_neg_reg;
        dec_next       = dec_reg;
        inc_e_next     = inc_e_reg;
        inc_ne_next    = inc_ne_reg;
        cnt_next       = cnt_reg;
        x_next         = x_reg;
        y_next         = y_reg;
        inb_next       = inb_reg;
        pix_next       = pix_reg;
        res_valid_next = res_valid_reg && res_stall;
        res_next       = res_reg;

        case (state_reg)
            ST_CLEAR:
            begin
                clr_addr_next = clr_addr_reg + AW'(1);
                if (clr_addr_reg == AW'(DEPTH - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (cmd_take)
                begin
                    op_next  = cmd.op;
                    xa_next  = cmd.x_start;
                    ya_next  = cmd.y_start;
                    xb_next  = cmd.x_end;
                    yb_next  = cmd.y_end;
                    inb_next = rd_inb;
                    pix_next = 1'b0;
                    if (cmd.op == OP_READ)
                    begin
                        state_next = ST_READ;
                    end
                    else
                    begin
                        state_next = ST_SETUP1;
                    end
                end
            end
            ST_SETUP1:
            begin
                dx_pos_next = xb_reg > xa_reg;
                dx_neg_next = xb_reg < xa_reg;
                dy_pos_next = yb_reg > ya_reg;
                dy_neg_next = yb_reg < ya_reg;
                adx_next    = (xb_reg < xa_reg) ? (xa_reg - xb_reg) : (xb_reg - xa_reg);
                ady_next    = (yb_reg < ya_reg) ? (ya_reg - yb_reg) : (yb_reg - ya_reg);
                state_next  = ST_SETUP2;
            end
            ST_SETUP2:
            begin
                // Equal magnitudes take the steep octants.
                swap_next    = swap_c;
                maj_neg_next = swap_c ? !dy_pos_reg : !dx_pos_reg;
                min_neg_next = swap_c ? dx_neg_reg : dy_neg_reg;
                dec_next     = {2'b00, dv, 1'b0} - {3'b000, du};
                inc_e_next   = {2'b00, dv, 1'b0};
                inc_ne_next  = {2'b00, dv, 1'b0} - {2'b00, du, 1'b0};
                cnt_next     = du;
                x_next       = xa_reg;
                y_next       = ya_reg;
                state_next   = ST_DRAW;
            end
            ST_DRAW:
            begin
                if (cnt_reg == '0)
                begin
                    state_next = ST_FINISH;
                end
                else
                begin
                    cnt_next = cnt_reg - 8'd1;
                    dec_next = dec_sum;
                    x_next   = swap_reg ? min_next_c : maj_next_c;
                    y_next   = swap_reg ? maj_next_c : min_next_c;
                end
            end
            ST_READ:
            begin
                pix_next   = ram_rdata[0] && inb_reg;
                state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                if (out_free)
                begin
                    res_valid_next    = 1'b1;
                    res_next.pixel_on = pix_reg;
                    res_next.was_read = (op_reg == OP_READ);
                    state_next        = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_addr_reg  <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_addr_reg  <= clr_addr_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg      <= op_next;
        xa_reg      <= xa_next;
        ya_reg      <= ya_next;
        xb_reg      <= xb_next;
        yb_reg      <= yb_next;
        adx_reg     <= adx_next;
        ady_reg     <= ady_next;
        dx_pos_reg  <= dx_pos_next;
        dx_neg_reg  <= dx_neg_next;
        dy_pos_reg  <= dy_pos_next;
        dy_neg_reg  <= dy_neg_next;
        swap_reg    <= swap_next;
        maj_neg_reg <= maj_neg_next;
        min_neg_reg <= min_neg_next;
        dec_reg     <= dec_next;
        inc_e_reg   <= inc_e_next;
        inc_ne_reg  <= inc_ne_next;
        cnt_reg     <= cnt_next;
        x_reg       <= x_next;
        y_reg       <= y_next;
        inb_reg     <= inb_next;
        pix_reg     <= pix_next;
        res_reg     <= res_next;
    end

    mlr_ram #(
        .WIDTH (1),
        .DEPTH (DEPTH)
    ) u_bitmap (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // The last pixel of a line is its second endpoint.
    a_last_pixel_is_end: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DRAW) && (cnt_reg == '0) |-> (x_reg == xb_reg) && (y_reg == yb_reg))
        else $error("line did not end at its second endpoint");

    // Every line pixel lies in the box spanned by the two endpoints.
    a_pixel_in_box: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DRAW) |->
            ((x_reg >= xa_reg) || (x_reg >= xb_reg)) &&
            ((x_reg <= xa_reg) || (x_reg <= xb_reg)) &&
            ((y_reg >= ya_reg) || (y_reg >= yb_reg)) &&
            ((y_reg <= ya_reg) || (y_reg <= yb_reg)))
        else $error("line pixel left the endpoint box");

    // A finished draw never reports a lit pixel.
    a_draw_result_dark: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res.was_read |-> !res.pixel_on)
        else $error("draw result carries a pixel bit");

    // No result appears while the bitmap is being swept.
    a_no_result_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CLEAR) |-> !res_valid)
        else $error("result during bitmap clear");

    // A new result is loaded only when the previous one was taken or absent.
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_stall |=> res_valid && $stable(res))
        else $error("waiting result was overwritten");

endmodule

`default_nettype wire

// ----- verif/tb_top.sv -----
// ----------------------------------------------------------------------------
// Midpoint line rasterizer testbench
// Sends draw and read items to the rasterizer and checks every result item
// against a bitmap that the testbench draws on its own in step with the block.
// Directed lines cover each octant, the diagonals, straight lines and the
// zero-length line; random traffic follows, with back-pressure and pauses.
// ----------------------------------------------------------------------------
module tb_top;

    import mlr_pkg::*;

    localparam int SCREEN_W  = 256;
    localparam int SCREEN_H  = 256;
    localparam int RUN_LIMIT = 1500000;

    logic      clk;
    logic      rst_n;
    logic      cmd_valid;
    logic      cmd_stall;
    cmd_item_t cmd;
    logic      res_valid;
    logic      res_stall;
    res_item_t res;

    // Bitmap as the block should hold it, and the results still owed.
    bit        screen_bits [0:SCREEN_W*SCREEN_H-1];
    res_item_t owed_results[$];

    int  error_count;
    int  cycle_count;
    int  hold_request;
    bit  send_idle;
    bit  recv_idle;
    int  last_xs;
    int  last_ys;
    int  last_xe;
    int  last_ye;

    midpoint_line_rasterizer_unit #(
        .SCREEN_WIDTH (SCREEN_W),
        .SCREEN_HEIGHT(SCREEN_H)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd_valid(cmd_valid),
        .cmd_stall(cmd_stall),
        .cmd      (cmd),
        .res_valid(res_valid),
        .res_stall(res_stall),
        .res      (res)
    );

    initial clk = 1'b0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > RUN_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Bitmap drawing
    // ------------------------------------------------------------------

    function automatic void light_pixel(int col, int row);
        if (col >= 0 && row >= 0 && col < SCREEN_W && row < SCREEN_H)
            screen_bits[row * SCREEN_W + col] = 1'b1;
    endfunction

    // Map a point of the canonical octant back to the screen.
    function automatic void light_canon(int u, int v, bit steep, int su, int sv);
        if (steep)
            light_pixel(sv * v, su * u);
        else
            light_pixel(su * u, sv * v);
    endfunction

    function automatic void trace_line(int xa, int ya, int xb, int yb);
        int dx, dy, adx, ady, su, sv, ua, va, ub, vb, du, dv, dec, u, v;
        bit rising, steep;
        dx  = xb - xa;
        dy  = yb - ya;
        adx = (dx < 0) ? -dx : dx;
        ady = (dy < 0) ? -dy : dy;
        // A vertical line counts as rising only when it goes down the rows.
        if (dx == 0)
            rising = (dy > 0);
        else
            rising = (dy == 0) || ((dx > 0) == (dy > 0));
        steep = !(adx > ady);
        if (steep)
            su = (yb > ya) ? 1 : -1;
        else
            su = (xb > xa) ? 1 : -1;
        sv = rising ? su : -su;
        if (steep)
        begin
            ua = su * ya;
            va = sv * xa;
            ub = su * yb;
            vb = sv * xb;
        end
        else
        begin
            ua = su * xa;
            va = sv * ya;
            ub = su * xb;
            vb = sv * yb;
        end
        du  = ub - ua;
        dv  = vb - va;
        dec = 2 * dv - du;
        u   = ua;
        v   = va;
        light_canon(u, v, steep, su, sv);
        while (u < ub)
        begin
            if (dec <= 0)
                dec += 2 * dv;
            else
            begin
                dec += 2 * (dv - du);
                v++;
            end
            u++;
            light_canon(u, v, steep, su, sv);
        end
    endfunction

    function automatic res_item_t rasterize(cmd_item_t c);
        res_item_t r;
        if (c.op == OP_READ)
        begin
            r.pixel_on = screen_bits[int'(c.y_start) * SCREEN_W + int'(c.x_start)];
            r.was_read = 1'b1;
        end
        else
        begin
            trace_line(c.x_start, c.y_start, c.x_end, c.y_end);
            r.pixel_on = 1'b0;
            r.was_read = 1'b0;
        end
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Item helpers
    // ------------------------------------------------------------------

    function automatic cmd_item_t make_cmd(logic op, int xs, int ys, int xe, int ye);
        cmd_item_t c;
        c.op      = op;
        c.x_start = xs[COORD_W-1:0];
        c.y_start = ys[COORD_W-1:0];
        c.x_end   = xe[COORD_W-1:0];
        c.y_end   = ye[COORD_W-1:0];
        return c;
    endfunction

    function automatic int pin_coord(int val);
        if (val < 0)
            return 0;
        if (val > 255)
            return 255;
        return val;
    endfunction

    // Offers one item and returns at the edge where the block takes it.
    task automatic send_cmd(cmd_item_t c);
        int gap;
        gap = send_idle ? $urandom_range(0, 7) : 0;
        if (gap > 0)
        begin
            cmd_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        cmd_valid <= 1'b1;
        cmd       <= c;
        do
            @(posedge clk);
        while (cmd_stall !== 1'b0);
        owed_results.push_back(rasterize(c));
    endtask

    task automatic release_cmd();
        cmd_valid <= 1'b0;
    endtask

    task automatic wait_all_results();
        do
            @(posedge clk);
        while (owed_results.size() != 0);
    endtask

    task automatic check_result(res_item_t got);
        res_item_t want;
        if (owed_results.size() == 0)
        begin
            $display("%0t: unexpected result, pixel_on %0b was_read %0b",
                     $time, got.pixel_on, got.was_read);
            error_count++;
        end
        else
        begin
            want = owed_results.pop_front();
            if (got.pixel_on !== want.pixel_on)
            begin
                $display("%0t: pixel_on mismatch, expected %0b, got %0b",
                         $time, want.pixel_on, got.pixel_on);
                error_count++;
            end
            if (got.was_read !== want.was_read)
            begin
                $display("%0t: was_read mismatch, expected %0b, got %0b",
                         $time, want.was_read, got.was_read);
                error_count++;
            end
        end
    endtask

    // Result side: takes each item, then stalls at random while recv_idle is set, or as long as hold_request asks.
    initial
    begin
        int stall_left;
        stall_left = 0;
        res_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n === 1'b1 && res_valid === 1'b1 && res_stall === 1'b0)
            begin
                check_result(res);
                stall_left = recv_idle ? $urandom_range(0, 7) : 0;
            end
            if (hold_request > 0)
            begin
                stall_left   = hold_request;
                hold_request = 0;
            end
            if (stall_left > 0)
            begin
                res_stall <= 1'b1;
                stall_left--;
            end
            else
                res_stall <= 1'b0;
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    task automatic test_directed();
        send_cmd(make_cmd(OP_READ, 0, 0, 255, 255));
        send_cmd(make_cmd(OP_DRAW, 0, 0, 255, 255));
        send_cmd(make_cmd(OP_READ, 255, 255, 0, 0));
        send_cmd(make_cmd(OP_READ, 128, 127, 0, 0));
        send_cmd(make_cmd(OP_DRAW, 255, 0, 0, 255));
        send_cmd(make_cmd(OP_READ, 0, 255, 255, 0));
        // Straight lines in both directions.
        send_cmd(make_cmd(OP_DRAW, 10, 5, 200, 5));
        send_cmd(make_cmd(OP_DRAW, 250, 7, 3, 7));
        send_cmd(make_cmd(OP_DRAW, 40, 0, 40, 255));
        send_cmd(make_cmd(OP_DRAW, 60, 255, 60, 0));
        // One line per octant around a common start point.
        send_cmd(make_cmd(OP_DRAW, 100, 100, 150, 120));
        send_cmd(make_cmd(OP_DRAW, 100, 100, 50, 80));
        send_cmd(make_cmd(OP_DRAW, 100, 100, 120, 150));
        send_cmd(make_cmd(OP_DRAW, 100, 100, 80, 50));
        send_cmd(make_cmd(OP_DRAW, 100, 100, 150, 80));
        send_cmd(make_cmd(OP_DRAW, 100, 100, 50, 120));
        send_cmd(make_cmd(OP_DRAW, 100, 100, 120, 50));
        send_cmd(make_cmd(OP_DRAW, 100, 100, 80, 150));
        send_cmd(make_cmd(OP_READ, 125, 110, 0, 0));
        send_cmd(make_cmd(OP_READ, 125, 111, 0, 0));
        // A line whose endpoints coincide sets just that pixel.
        send_cmd(make_cmd(OP_DRAW, 77, 33, 77, 33));
        send_cmd(make_cmd(OP_READ, 77, 33, 255, 255));
        send_cmd(make_cmd(OP_READ, 78, 33, 255, 255));
        send_cmd(make_cmd(OP_DRAW, 255, 255, 255, 255));
    endtask

    task automatic test_random_traffic(int count);
        int xs, ys, xe, ye, t;
        for (int i = 0; i < count; i++)
        begin
            // Idling comes and goes in stretches.
            send_idle = ((i / 60) % 3) != 1;
            recv_idle = ((i / 45) % 3) != 2;
            if ($urandom_range(0, 9) < 6)
            begin
                xs = $urandom_range(0, 255);
                ys = $urandom_range(0, 255);
                if ($urandom_range(0, 9) < 7)
                begin
                    xe = pin_coord(xs + $urandom_range(0, 30) - 15);
                    ye = pin_coord(ys + $urandom_range(0, 30) - 15);
                end
                else
                begin
                    xe = $urandom_range(0, 255);
                    ye = $urandom_range(0, 255);
                end
                last_xs = xs;
                last_ys = ys;
                last_xe = xe;
                last_ye = ye;
                send_cmd(make_cmd(OP_DRAW, xs, ys, xe, ye));
            end
            else
            begin
                if ($urandom_range(0, 1) == 0)
                begin
                    // Probe on or next to the most recent line.
                    t  = $urandom_range(0, 16);
                    xs = pin_coord(last_xs + (last_xe - last_xs) * t / 16
                                   + $urandom_range(0, 2) - 1);
                    ys = pin_coord(last_ys + (last_ye - last_ys) * t / 16
                                   + $urandom_range(0, 2) - 1);
                end
                else
                begin
                    xs = $urandom_range(0, 255);
                    ys = $urandom_range(0, 255);
                end
                send_cmd(make_cmd(OP_READ, xs, ys,
                                  $urandom_range(0, 255), $urandom_range(0, 255)));
            end
        end
        send_idle = 1'b1;
        recv_idle = 1'b1;
    endtask

    // The result side holds off for a long stretch while items keep coming.
    task automatic test_backpressure();
        int xs, ys;
        send_idle    = 1'b0;
        hold_request = 1500;
        for (int i = 0; i < 12; i++)
        begin
            xs = $urandom_range(0, 255);
            ys = $urandom_range(0, 255);
            if (i % 3 == 2)
                send_cmd(make_cmd(OP_READ, xs, ys, 0, 0));
            else
                send_cmd(make_cmd(OP_DRAW, xs, ys, pin_coord(xs + i), pin_coord(ys - i)));
        end
        send_idle = 1'b1;
    endtask

    // The sender stops until every owed result is back, then goes on.
    task automatic test_drain_pause();
        int xs, ys;
        for (int round = 0; round < 2; round++)
        begin
            for (int i = 0; i < 8; i++)
            begin
                xs = $urandom_range(0, 255);
                ys = $urandom_range(0, 255);
                if (i % 2 == 0)
                    send_cmd(make_cmd(OP_DRAW, xs, ys, 255 - xs, ys));
                else
                    send_cmd(make_cmd(OP_READ, 255 - xs, ys, 0, 0));
            end
            release_cmd();
            wait_all_results();
        end
    endtask

    initial
    begin
        error_count  = 0;
        cycle_count  = 0;
        hold_request = 0;
        send_idle    = 1'b1;
        recv_idle    = 1'b1;
        last_xs      = 0;
        last_ys      = 0;
        last_xe      = 255;
        last_ye      = 255;
        rst_n     <= 1'b0;
        cmd_valid <= 1'b0;
        cmd       <= '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_random_traffic(500);
        test_backpressure();
        test_drain_pause();

        release_cmd();
        wait_all_results();
        repeat (300) @(posedge clk);
        if (owed_results.size() != 0)
        begin
            $display("%0t: %0d results never arrived", $time, owed_results.size());
            error_count++;
        end
        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

// ----- files.f -----
rtl/mlr_pkg.sv
rtl/mlr_ram.sv
rtl/midpoint_line_rasterizer_unit.sv
verif/tb_top.sv
